[rtl/assert_macros.svh]
// Assertion macros shared by the price ladder RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define OBPL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define OBPL_ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

[rtl/obpl_pkg.sv]
// Shared constants, codes and controller/datapath structs of the price ladder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package obpl_pkg;

  localparam int ORDER_SLOTS  = 256;
  localparam int PRICE_LEVELS = 32;
  localparam int SHOWN_DEPTH  = 5;

  localparam int SLOT_W = $clog2(ORDER_SLOTS);
  localparam int LVL_W  = $clog2(PRICE_LEVELS);
  localparam int CNT_W  = LVL_W + 1;
  localparam int RANK_W = 3;

  typedef enum logic [1:0] {
    MODE_NEW   = 2'd0,
    MODE_MOD   = 2'd1,
    MODE_CAN   = 2'd2,
    MODE_TRADE = 2'd3
  } mode_t;

  typedef struct packed {
    logic load;
    logic ord_scan;
    logic ord_scan_sell;
    logic ord_wr;
    logic ord_free;
    logic ord_trade;
    logic lvl_scan;
    logic lside;
    logic lprice_ord;
    logic lqty_ord;
    logic lvl_add;
    logic lvl_rem;
    logic emit;
    logic drop;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  sell;
    logic  inst_match;
    logic  ord_done;
    logic  ord_hit;
    logic  ord_free;
    logic  lvl_done;
    logic  lvl_fail;
    logic  em_busy;
  } stat_t;

endpackage

`default_nettype wire

[rtl/obpl_levels.sv]
// One side of the price ladder: sorted level registers, a one-entry-per-cycle
// scan unit and the insert/remove shifter. Depends on obpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module obpl_levels import obpl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ask,
  input  logic             start,
  input  logic             add,
  input  logic             rem,
  input  logic [31:0]      price,
  input  logic [31:0]      qty,
  input  logic [LVL_W-1:0] rd_idx,
  output logic             done,
  output logic             fail,
  output logic             rd_valid,
  output logic [31:0]      rd_price,
  output logic [31:0]      rd_total
);

  logic [PRICE_LEVELS-1:0] v_r, v_nxt;
  logic [31:0]             p_r [PRICE_LEVELS];
  logic [31:0]             p_nxt [PRICE_LEVELS];
  logic [31:0]             t_r [PRICE_LEVELS];
  logic [31:0]             t_nxt [PRICE_LEVELS];

  logic             busy_r, done_r, match_r;
  logic [LVL_W-1:0] j_r, idx_r;
  logic [CNT_W-1:0] cnt_r, pos_r;
  logic [31:0]      mtot_r;

  logic [LVL_W-1:0] ridx;
  logic             e_v;
  logic [31:0]      e_p, e_t;
  logic             better;
  logic [32:0]      sum;

  assign ridx   = busy_r ? j_r : rd_idx;
  assign e_v    = v_r[ridx];
  assign e_p    = p_r[ridx];
  assign e_t    = t_r[ridx];
  assign better = ask ? (e_p < price) : (e_p > price);
  assign sum    = {1'b0, mtot_r} + {1'b0, qty};

  assign done     = done_r;
  assign fail     = !match_r && (qty != 32'd0) && (cnt_r == CNT_W'(PRICE_LEVELS));
  assign rd_valid = e_v;
  assign rd_price = e_v ? e_p : 32'd0;
  assign rd_total = e_v ? e_t : 32'd0;

  // scan: find the price, count live levels, rank position for an insert
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      match_r <= 1'b0;
      j_r     <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      done_r  <= 1'b0;
      match_r <= 1'b0;
      j_r     <= '0;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else if (busy_r) begin
      if (e_v) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (better) begin
          pos_r <= pos_r + CNT_W'(1);
        end
        if (e_p == price && !match_r) begin
          match_r <= 1'b1;
          idx_r   <= j_r;
        end
      end
      if (j_r == LVL_W'(PRICE_LEVELS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        j_r <= j_r + LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && e_v && e_p == price && !match_r) begin
      mtot_r <= e_t;
    end
  end

  always_comb begin
    v_nxt = v_r;
    p_nxt = p_r;
    t_nxt = t_r;
    if (add && !fail) begin
      if (match_r) begin
        t_nxt[idx_r] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end else if (qty != 32'd0) begin
        if (pos_r == '0) begin
          v_nxt[0] = 1'b1;
          p_nxt[0] = price;
          t_nxt[0] = qty;
        end
        for (int i = 1; i < PRICE_LEVELS; i++) begin
          if (CNT_W'(i) > pos_r) begin
            v_nxt[i] = v_r[i-1];
            p_nxt[i] = p_r[i-1];
            t_nxt[i] = t_r[i-1];
          end else if (CNT_W'(i) == pos_r) begin
            v_nxt[i] = 1'b1;
            p_nxt[i] = price;
            t_nxt[i] = qty;
          end
        end
      end
    end else if (rem && match_r) begin
      if (mtot_r > qty) begin
        t_nxt[idx_r] = mtot_r - qty;
      end else begin
        // drop the level and close the gap
        for (int i = 0; i < PRICE_LEVELS - 1; i++) begin
          if (LVL_W'(i) >= idx_r) begin
            v_nxt[i] = v_r[i+1];
            p_nxt[i] = p_r[i+1];
            t_nxt[i] = t_r[i+1];
          end
        end
        v_nxt[PRICE_LEVELS-1] = 1'b0;
        p_nxt[PRICE_LEVELS-1] = 32'd0;
        t_nxt[PRICE_LEVELS-1] = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    t_r <= t_nxt;
  end

endmodule

`default_nettype wire

[rtl/obpl_dp.sv]
// Datapath: input word capture, order table memory with its scan unit,
// both level ladders and the snapshot output register. Depends on obpl_pkg,
// obpl_levels and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module obpl_dp import obpl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [1:0]       in_mode,
  input  logic [31:0]      in_instrument,
  input  logic [31:0]      in_order_key,
  input  logic [31:0]      in_sell_order_key,
  input  logic             in_is_sell,
  input  logic [31:0]      in_price,
  input  logic [31:0]      in_amount,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_ask_side,
  output logic [RANK_W-1:0] out_level_index,
  output logic             out_level_valid,
  output logic [31:0]      out_level_price,
  output logic [31:0]      out_level_total,
  output logic             out_dropped,
  output logic             out_last
);

  logic [31:0] watched_r;
  logic [1:0]  md_r;
  logic [31:0] inst_r, key_r, skey_r, price_r, amt_r;
  logic        sell_r;

  // order table
  logic [31:0]            ident_mem [ORDER_SLOTS];
  logic [31:0]            oprice_mem [ORDER_SLOTS];
  logic [31:0]            oleft_mem [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0] used_r;

  logic              os_busy_r, os_vld_r, os_done_r;
  logic [SLOT_W-1:0] os_a_r, os_ad_r;
  logic [31:0]       rd_ident_r, rd_price_r, rd_left_r, scan_key_r;
  logic              hit_r, free_r;
  logic [SLOT_W-1:0] hit_slot_r, free_slot_r;
  logic [31:0]       hit_price_r, hit_left_r;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  logic [31:0]       mem_wprice, mem_wleft;
  logic              trade_out;

  // ladders
  logic        lside_r, lpo_r, lqo_r;
  logic [31:0] lv_price, lv_qty;
  logic        b_done, b_fail, b_v, a_done, a_fail, a_v;
  logic [31:0] b_p, b_t, a_p, a_t;

  // snapshot
  logic              em_busy_r, em_side_r, em_drop_r;
  logic [RANK_W-1:0] em_k_r;
  logic              em_load, em_end_rank;
  logic              out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      watched_r <= 32'd0;
    end else if (cfg_wr_en) begin
      watched_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      md_r    <= in_mode;
      inst_r  <= in_instrument;
      key_r   <= in_order_key;
      skey_r  <= in_sell_order_key;
      sell_r  <= in_is_sell;
      price_r <= in_price;
      amt_r   <= in_amount;
    end
  end

  assign trade_out = amt_r >= hit_left_r;

  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = hit_slot_r;
    mem_wprice = price_r;
    mem_wleft  = amt_r;
    if (cmd.ord_wr) begin
      mem_we = 1'b1;
      mem_wa = hit_r ? hit_slot_r : free_slot_r;
    end else if (cmd.ord_trade && !trade_out) begin
      mem_we     = 1'b1;
      mem_wprice = hit_price_r;
      mem_wleft  = hit_left_r - amt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ident_mem[mem_wa]  <= scan_key_r;
      oprice_mem[mem_wa] <= mem_wprice;
      oleft_mem[mem_wa]  <= mem_wleft;
    end
    rd_ident_r <= ident_mem[os_a_r];
    rd_price_r <= oprice_mem[os_a_r];
    rd_left_r  <= oleft_mem[os_a_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.ord_wr) begin
      used_r[mem_wa] <= 1'b1;
    end else if (cmd.ord_free || (cmd.ord_trade && trade_out)) begin
      used_r[hit_slot_r] <= 1'b0;
    end
  end

  // order scan: one slot per cycle, compare in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      os_busy_r <= 1'b0;
      os_vld_r  <= 1'b0;
      os_done_r <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      os_a_r    <= '0;
    end else if (cmd.ord_scan) begin
      os_busy_r  <= 1'b1;
      os_vld_r   <= 1'b0;
      os_done_r  <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      os_a_r     <= '0;
      scan_key_r <= cmd.ord_scan_sell ? skey_r : key_r;
    end else begin
      os_vld_r <= os_busy_r;
      os_ad_r  <= os_a_r;
      if (os_busy_r) begin
        if (os_a_r == SLOT_W'(ORDER_SLOTS - 1)) begin
          os_busy_r <= 1'b0;
        end else begin
          os_a_r <= os_a_r + SLOT_W'(1);
        end
      end
      if (os_vld_r) begin
        if (used_r[os_ad_r] && rd_ident_r == scan_key_r && !hit_r) begin
          hit_r       <= 1'b1;
          hit_slot_r  <= os_ad_r;
          hit_price_r <= rd_price_r;
          hit_left_r  <= rd_left_r;
        end
        if (!used_r[os_ad_r] && !free_r) begin
          free_r      <= 1'b1;
          free_slot_r <= os_ad_r;
        end
        if (os_ad_r == SLOT_W'(ORDER_SLOTS - 1)) begin
          os_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lside_r <= 1'b0;
      lpo_r   <= 1'b0;
      lqo_r   <= 1'b0;
    end else if (cmd.lvl_scan) begin
      lside_r <= cmd.lside;
      lpo_r   <= cmd.lprice_ord;
      lqo_r   <= cmd.lqty_ord;
    end
  end

  assign lv_price = lpo_r ? hit_price_r : price_r;
  assign lv_qty   = lqo_r ? hit_left_r : amt_r;

  obpl_levels u_bid (
    .clk      (clk),
    .rst_n    (rst_n),
    .ask      (1'b0),
    .start    (cmd.lvl_scan && !cmd.lside),
    .add      (cmd.lvl_add && !lside_r),
    .rem      (cmd.lvl_rem && !lside_r),
    .price    (lv_price),
    .qty      (lv_qty),
    .rd_idx   (LVL_W'(em_k_r)),
    .done     (b_done),
    .fail     (b_fail),
    .rd_valid (b_v),
    .rd_price (b_p),
    .rd_total (b_t)
  );

  obpl_levels u_ask (
    .clk      (clk),
    .rst_n    (rst_n),
    .ask      (1'b1),
    .start    (cmd.lvl_scan && cmd.lside),
    .add      (cmd.lvl_add && lside_r),
    .rem      (cmd.lvl_rem && lside_r),
    .price    (lv_price),
    .qty      (lv_qty),
    .rd_idx   (LVL_W'(em_k_r)),
    .done     (a_done),
    .fail     (a_fail),
    .rd_valid (a_v),
    .rd_price (a_p),
    .rd_total (a_t)
  );

  // snapshot: bid ranks then ask ranks, one word per free output slot
  assign em_load     = em_busy_r && (!out_valid_r || out_ready);
  assign em_end_rank = em_k_r == RANK_W'(SHOWN_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_busy_r   <= 1'b0;
      em_side_r   <= 1'b0;
      em_k_r      <= '0;
      em_drop_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        em_busy_r <= 1'b1;
        em_side_r <= 1'b0;
        em_k_r    <= '0;
        em_drop_r <= cmd.drop;
      end else if (em_load) begin
        if (em_end_rank) begin
          em_k_r <= '0;
          if (em_side_r) begin
            em_busy_r <= 1'b0;
          end else begin
            em_side_r <= 1'b1;
          end
        end else begin
          em_k_r <= em_k_r + RANK_W'(1);
        end
      end
      if (em_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (em_load) begin
      out_ask_side    <= em_side_r;
      out_level_index <= em_k_r;
      out_level_valid <= em_side_r ? a_v : b_v;
      out_level_price <= em_side_r ? a_p : b_p;
      out_level_total <= em_side_r ? a_t : b_t;
      out_dropped     <= em_drop_r;
      out_last        <= em_side_r && em_end_rank;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.mode       = mode_t'(md_r);
  assign stat.sell       = sell_r;
  assign stat.inst_match = inst_r == watched_r;
  assign stat.ord_done   = os_done_r;
  assign stat.ord_hit    = hit_r;
  assign stat.ord_free   = free_r;
  assign stat.lvl_done   = lside_r ? a_done : b_done;
  assign stat.lvl_fail   = lside_r ? a_fail : b_fail;
  assign stat.em_busy    = em_busy_r;

  `OBPL_ASSERT(a_scan_idle, clk, rst_n, cmd.ord_scan |-> !os_busy_r, "order scan restarted")
  `OBPL_ASSERT(a_emit_idle, clk, rst_n, cmd.emit |-> !em_busy_r, "snapshot restarted")
  `OBPL_ASSERT_NEXT(a_emit_fill, clk, rst_n, em_busy_r && !out_valid_r, out_valid_r, "no word")

endmodule

`default_nettype wire

[rtl/obpl_ctrl.sv]
// Controller: sequences order lookups, level updates and the snapshot
// for each event word. Depends on obpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module obpl_ctrl import obpl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHK   = 7'b0000010,
    S_OSCAN = 7'b0000100,
    S_ODEC  = 7'b0001000,
    S_LSCAN = 7'b0010000,
    S_LOP   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    ST_NEW,
    ST_MOD_REM,
    ST_MOD_ADD,
    ST_MOD_RST,
    ST_CAN,
    ST_TR_BUY,
    ST_TR_SELL
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= ST_NEW;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!stat.inst_match) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.ord_scan = 1'b1;
          state_nxt    = S_OSCAN;
          case (stat.mode)
            MODE_NEW: step_nxt = ST_NEW;
            MODE_MOD: step_nxt = ST_MOD_REM;
            MODE_CAN: step_nxt = ST_CAN;
            default:  step_nxt = ST_TR_BUY;
          endcase
        end
      end
      S_OSCAN: begin
        if (stat.ord_done) begin
          state_nxt = S_ODEC;
        end
      end
      S_ODEC: begin
        case (step_r)
          ST_NEW: begin
            if (!stat.ord_hit && !stat.ord_free) begin
              cmd.emit  = 1'b1;
              cmd.drop  = 1'b1;
              state_nxt = S_EMIT;
            end else begin
              cmd.lvl_scan = 1'b1;
              cmd.lside    = stat.sell;
              state_nxt    = S_LSCAN;
            end
          end
          ST_MOD_REM, ST_CAN: begin
            if (!stat.ord_hit) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.lvl_scan   = 1'b1;
              cmd.lside      = stat.sell;
              cmd.lprice_ord = 1'b1;
              cmd.lqty_ord   = 1'b1;
              state_nxt      = S_LSCAN;
            end
          end
          ST_TR_BUY: begin
            if (!stat.ord_hit) begin
              cmd.ord_scan      = 1'b1;
              cmd.ord_scan_sell = 1'b1;
              step_nxt          = ST_TR_SELL;
              state_nxt         = S_OSCAN;
            end else begin
              cmd.lvl_scan   = 1'b1;
              cmd.lprice_ord = 1'b1;
              state_nxt      = S_LSCAN;
            end
          end
          ST_TR_SELL: begin
            if (!stat.ord_hit) begin
              cmd.emit  = 1'b1;
              state_nxt = S_EMIT;
            end else begin
              cmd.lvl_scan   = 1'b1;
              cmd.lside      = 1'b1;
              cmd.lprice_ord = 1'b1;
              state_nxt      = S_LSCAN;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LSCAN: begin
        if (stat.lvl_done) begin
          state_nxt = S_LOP;
        end
      end
      S_LOP: begin
        case (step_r)
          ST_NEW: begin
            cmd.lvl_add = 1'b1;
            cmd.emit    = 1'b1;
            state_nxt   = S_EMIT;
            if (stat.lvl_fail) begin
              cmd.drop = 1'b1;
            end else begin
              cmd.ord_wr = 1'b1;
            end
          end
          ST_MOD_REM: begin
            cmd.lvl_rem  = 1'b1;
            cmd.lvl_scan = 1'b1;
            cmd.lside    = stat.sell;
            step_nxt     = ST_MOD_ADD;
            state_nxt    = S_LSCAN;
          end
          ST_MOD_ADD: begin
            cmd.lvl_add = 1'b1;
            if (stat.lvl_fail) begin
              // put the old quantity back on its level
              cmd.lvl_scan   = 1'b1;
              cmd.lside      = stat.sell;
              cmd.lprice_ord = 1'b1;
              cmd.lqty_ord   = 1'b1;
              step_nxt       = ST_MOD_RST;
              state_nxt      = S_LSCAN;
            end else begin
              cmd.ord_wr = 1'b1;
              cmd.emit   = 1'b1;
              state_nxt  = S_EMIT;
            end
          end
          ST_MOD_RST: begin
            cmd.lvl_add = 1'b1;
            cmd.emit    = 1'b1;
            cmd.drop    = 1'b1;
            state_nxt   = S_EMIT;
          end
          ST_CAN: begin
            cmd.lvl_rem  = 1'b1;
            cmd.ord_free = 1'b1;
            cmd.emit     = 1'b1;
            state_nxt    = S_EMIT;
          end
          ST_TR_BUY: begin
            cmd.lvl_rem       = 1'b1;
            cmd.ord_trade     = 1'b1;
            cmd.ord_scan      = 1'b1;
            cmd.ord_scan_sell = 1'b1;
            step_nxt          = ST_TR_SELL;
            state_nxt         = S_OSCAN;
          end
          ST_TR_SELL: begin
            cmd.lvl_rem   = 1'b1;
            cmd.ord_trade = 1'b1;
            cmd.emit      = 1'b1;
            state_nxt     = S_EMIT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (!stat.em_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/order_book_price_ladder.sv]
// Top level of the price ladder: controller plus datapath.
// Depends on obpl_pkg, obpl_ctrl and obpl_dp.
//
// Usage: event words (new, modify, cancel, trade) enter on the in_ valid/ready
// channel; one event is in work at a time, in_ready is high only while idle.
// cfg_wr_en/cfg_wr_data set the watched instrument; write only while idle.
// Events for another instrument, and modify/cancel of an unknown id, are taken
// and produce nothing. Every other event yields a ten-word snapshot on the out_
// channel: five bid ranks best first, then five ask ranks, out_last on the final.
// Flow: each order lookup walks the order table memory through its single
// read port, and each level step scans one ladder entry per cycle. A new or
// cancel event runs an order lookup, then a level step; a modify removes the
// old quantity from its level, adds the new one and puts the old one back
// when the new level does not fit; a trade looks up the buy, then the sell
// order, each with a level step when found. The snapshot drains at one word
// per cycle while out_ready is high and holds in the output register when
// the receiver stalls. Reset empties the order table and both ladders at
// once, clears the watched instrument to zero and drops any word in flight.
`timescale 1ns / 1ps
`default_nettype none

module order_book_price_ladder import obpl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [31:0]       in_instrument,
  input  logic [31:0]       in_order_key,
  input  logic [31:0]       in_sell_order_key,
  input  logic              in_is_sell,
  input  logic [31:0]       in_price,
  input  logic [31:0]       in_amount,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ask_side,
  output logic [RANK_W-1:0] out_level_index,
  output logic              out_level_valid,
  output logic [31:0]       out_level_price,
  output logic [31:0]       out_level_total,
  output logic              out_dropped,
  output logic              out_last
);

  cmd_t  cmd;
  stat_t stat;

  obpl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  obpl_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_instrument     (in_instrument),
    .in_order_key      (in_order_key),
    .in_sell_order_key (in_sell_order_key),
    .in_is_sell        (in_is_sell),
    .in_price          (in_price),
    .in_amount         (in_amount),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ask_side      (out_ask_side),
    .out_level_index   (out_level_index),
    .out_level_valid   (out_level_valid),
    .out_level_price   (out_level_price),
    .out_level_total   (out_level_total),
    .out_dropped       (out_dropped),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire
